// ----- rtl/windowed_energy_peak_vad_core_defines.svh -----
// Assertion macros shared by the voice activity detector RTL.
// Included by wepvad_segment, the module that carries concurrent assertions; needs nothing else.
`ifndef WINDOWED_ENERGY_PEAK_VAD_CORE_DEFINES_SVH
`define WINDOWED_ENERGY_PEAK_VAD_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define WEPVAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wepvad assertion failed");

// Next-cycle implication, disabled while reset is held.
`define WEPVAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wepvad assertion failed");

`endif

// ----- rtl/wepvad_pkg.sv -----
// Shared constants, register codes and types for the voice activity detector.
// No dependencies; used by every module of the block.
package wepvad_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_MAX_DEF      = 4096;
  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int RUN_COUNT_WIDTH_DEF = 24;

  // Fixed field widths.
  localparam int LEN_W      = 13;
  localparam int SUM_W      = 48;
  localparam int PEAK_THR_W = 15;
  localparam int RUN_CFG_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int OUT_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SUM_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THR        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SOUND       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SILENCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER        = 3'd5;

  // Register values after reset.
  localparam logic [LEN_W-1:0]      LEN_RST         = 13'd882;
  localparam logic [SUM_W-1:0]      SUM_THR_RST     = 48'd9470402888;
  localparam logic [PEAK_THR_W-1:0] PEAK_THR_RST    = 15'd655;
  localparam logic [RUN_CFG_W-1:0]  MIN_SOUND_RST   = 24'd4410;
  localparam logic [RUN_CFG_W-1:0]  MIN_SILENCE_RST = 24'd2205;
  localparam logic [RUN_CFG_W-1:0]  HANGOVER_RST    = 24'd4410;

  // Finished-window event handed from the window stage to the segment stage.
  typedef struct packed {
    logic valid;
    logic active;
  } win_evt_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/wepvad_window.sv -----
// Window accumulation: magnitude, square, saturating sum, peak and fill count,
// then the energy and peak threshold tests. Depends on wepvad_pkg.
module wepvad_window #(
  parameter int WINDOW_MAX   = wepvad_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = wepvad_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_take,
  input  logic [SAMPLE_WIDTH-1:0]               in_sample,
  input  logic [wepvad_pkg::max_int(wepvad_pkg::LEN_W,
                $clog2(WINDOW_MAX+1))-1:0]      len_eff,
  input  logic [wepvad_pkg::SUM_W-1:0]          sum_thr,
  input  logic [wepvad_pkg::PEAK_THR_W-1:0]     peak_thr,
  output wepvad_pkg::win_evt_t                  evt
);

  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = wepvad_pkg::max_int(wepvad_pkg::LEN_W, FILL_W);
  localparam int SQ_W   = 2 * SAMPLE_WIDTH - 1;
  localparam int SUM_W  = wepvad_pkg::SUM_W;
  localparam int PK_W   = wepvad_pkg::max_int(SAMPLE_WIDTH, wepvad_pkg::PEAK_THR_W);

  // Stage 1: input register.
  logic                    s1_valid_r;
  logic [SAMPLE_WIDTH-1:0] s1_sample_r;

  // Stage 2: magnitude and square.
  logic                    s2_valid_r;
  logic [SAMPLE_WIDTH-1:0] s2_mag_r;
  logic [SQ_W-1:0]         s2_sq_r;
  logic [SAMPLE_WIDTH-1:0] mag_nxt;
  logic [2*SAMPLE_WIDTH-1:0] prod;

  // Stage 3: window state and finished-window totals.
  logic [SUM_W-1:0]        energy_sum_r;
  logic [SAMPLE_WIDTH-1:0] peak_level_r;
  logic [FILL_W-1:0]       window_fill_r;
  logic                    tot_valid_r;
  logic [SUM_W-1:0]        tot_sum_r;
  logic [SAMPLE_WIDTH-1:0] tot_peak_r;
  logic [SUM_W:0]          sum_add;
  logic [SUM_W-1:0]        sum_nxt;
  logic [SAMPLE_WIDTH-1:0] peak_nxt;
  logic [CMP_W-1:0]        fill_inc;
  logic                    win_end;

  // Stage 4: threshold tests.
  logic                    act_valid_r;
  logic                    active_r;
  logic                    active_nxt;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_take) begin
      s1_sample_r <= in_sample;
    end
  end

  // Magnitude by negation; the most negative code yields its unsigned magnitude.
  // The signed square equals the squared magnitude and fits in SQ_W bits.
  always_comb begin
    mag_nxt = s1_sample_r[SAMPLE_WIDTH-1] ? (~s1_sample_r + 1'b1) : s1_sample_r;
    prod    = $signed(s1_sample_r) * $signed(s1_sample_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mag_r <= mag_nxt;
      s2_sq_r  <= prod[SQ_W-1:0];
    end
  end

  // Saturating accumulate, peak hold and window end detection.
  always_comb begin
    sum_add  = {1'b0, energy_sum_r} + (SUM_W + 1)'(s2_sq_r);
    sum_nxt  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    peak_nxt = (s2_mag_r > peak_level_r) ? s2_mag_r : peak_level_r;
    fill_inc = CMP_W'(window_fill_r) + 1'b1;
    win_end  = (fill_inc >= len_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_sum_r  <= '0;
      peak_level_r  <= '0;
      window_fill_r <= '0;
      tot_valid_r   <= 1'b0;
    end else if (adv) begin
      tot_valid_r <= s2_valid_r && win_end;
      if (s2_valid_r) begin
        if (win_end) begin
          energy_sum_r  <= '0;
          peak_level_r  <= '0;
          window_fill_r <= '0;
        end else begin
          energy_sum_r  <= sum_nxt;
          peak_level_r  <= peak_nxt;
          window_fill_r <= fill_inc[FILL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && win_end) begin
      tot_sum_r  <= sum_nxt;
      tot_peak_r <= peak_nxt;
    end
  end

  // Energy and peak tests on the finished window.
  always_comb begin
    active_nxt = (tot_sum_r > sum_thr) || (PK_W'(tot_peak_r) > PK_W'(peak_thr));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
    end else if (adv) begin
      act_valid_r <= tot_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tot_valid_r) begin
      active_r <= active_nxt;
    end
  end

  assign evt.valid  = act_valid_r;
  assign evt.active = active_r;

endmodule

// ----- rtl/wepvad_segment.sv -----
// Segment tracking: sound and silence run counters, segment flag, hangover,
// and the result register with its skid stage. Depends on wepvad_pkg and the
// assertion macro header.
`include "windowed_energy_peak_vad_core_defines.svh"

module wepvad_segment #(
  parameter int WINDOW_MAX      = wepvad_pkg::WINDOW_MAX_DEF,
  parameter int RUN_COUNT_WIDTH = wepvad_pkg::RUN_COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wepvad_pkg::win_evt_t                  evt,
  input  logic [wepvad_pkg::max_int(wepvad_pkg::LEN_W,
                $clog2(WINDOW_MAX+1))-1:0]      step,
  input  logic [wepvad_pkg::RUN_CFG_W-1:0]      min_sound,
  input  logic [wepvad_pkg::RUN_CFG_W-1:0]      min_silence,
  input  logic [wepvad_pkg::RUN_CFG_W-1:0]      hangover,
  output logic                                  adv,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [wepvad_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int CMP_W  = wepvad_pkg::max_int(wepvad_pkg::LEN_W, $clog2(WINDOW_MAX + 1));
  localparam int ADD_W  = wepvad_pkg::max_int(RUN_COUNT_WIDTH, CMP_W) + 1;
  localparam int RC_W   = wepvad_pkg::max_int(RUN_COUNT_WIDTH, wepvad_pkg::RUN_CFG_W);
  localparam int RES_W  = 5;

  logic                       segment_flag_r;
  logic [RUN_COUNT_WIDTH-1:0] sound_run_r;
  logic [RUN_COUNT_WIDTH-1:0] silence_run_r;

  logic [ADD_W-1:0]           sound_add;
  logic [ADD_W-1:0]           silence_add;
  logic [RUN_COUNT_WIDTH-1:0] sound_sat;
  logic [RUN_COUNT_WIDTH-1:0] silence_sat;
  logic [RUN_COUNT_WIDTH-1:0] sound_nxt;
  logic [RUN_COUNT_WIDTH-1:0] silence_nxt;
  logic                       segment_nxt;
  logic                       start_nxt;
  logic                       end_nxt;
  logic                       keep_nxt;
  logic                       accept_new;

  // Result fields from the lowest bit up: active, in segment, start, end, keep.
  logic [RES_W-1:0]           res_nxt;
  logic                       out_valid_r;
  logic [RES_W-1:0]           out_res_r;
  logic                       skid_valid_r;
  logic [RES_W-1:0]           skid_res_r;

  // The pipeline moves unless a result waits in the skid register.
  assign adv        = !skid_valid_r;
  assign accept_new = evt.valid && adv;

  // Saturating run updates and segment decisions.
  always_comb begin
    sound_add   = ADD_W'(sound_run_r) + ADD_W'(step);
    silence_add = ADD_W'(silence_run_r) + ADD_W'(step);
    sound_sat   = (sound_add > ADD_W'({RUN_COUNT_WIDTH{1'b1}})) ?
                  {RUN_COUNT_WIDTH{1'b1}} : sound_add[RUN_COUNT_WIDTH-1:0];
    silence_sat = (silence_add > ADD_W'({RUN_COUNT_WIDTH{1'b1}})) ?
                  {RUN_COUNT_WIDTH{1'b1}} : silence_add[RUN_COUNT_WIDTH-1:0];
    start_nxt   = 1'b0;
    end_nxt     = 1'b0;
    segment_nxt = segment_flag_r;
    if (evt.active) begin
      sound_nxt   = sound_sat;
      silence_nxt = '0;
      if (!segment_flag_r && (RC_W'(sound_sat) >= RC_W'(min_sound))) begin
        segment_nxt = 1'b1;
        start_nxt   = 1'b1;
      end
    end else begin
      sound_nxt   = '0;
      silence_nxt = silence_sat;
      if (segment_flag_r && (RC_W'(silence_sat) >= RC_W'(min_silence))) begin
        segment_nxt = 1'b0;
        end_nxt     = 1'b1;
      end
    end
    keep_nxt = segment_nxt ||
               ((silence_nxt != '0) && (RC_W'(silence_nxt) <= RC_W'(hangover)));
    res_nxt  = {keep_nxt, end_nxt, start_nxt, segment_nxt, evt.active};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_flag_r <= 1'b0;
      sound_run_r    <= '0;
      silence_run_r  <= '0;
    end else if (accept_new) begin
      segment_flag_r <= segment_nxt;
      sound_run_r    <= sound_nxt;
      silence_run_r  <= silence_nxt;
    end
  end

  // Result register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept_new;
      end
    end else if (accept_new) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_res_r <= skid_valid_r ? skid_res_r : res_nxt;
    end else if (accept_new) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = wepvad_pkg::OUT_DATA_W'(out_res_r);

  // The skid register only fills behind a result that is being held.
  `WEPVAD_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // A window that opens a segment reports itself inside it.
  `WEPVAD_ASSERT_NOW(a_start_in_seg, clk, rst_n, out_valid_r && out_res_r[2], out_res_r[1])
  // A window that closes a segment reports itself outside it.
  `WEPVAD_ASSERT_NOW(a_end_out_seg, clk, rst_n, out_valid_r && out_res_r[3], !out_res_r[1])
  // A held result stays put until the beat completes.
  `WEPVAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_tready,
                      out_valid_r && $stable(out_res_r))

endmodule

// ----- rtl/windowed_energy_peak_vad_core.sv -----
// Windowed energy and peak voice activity detector: one sample beat in per
// clock while in_tready is high; a beat of five flags out at the end of every
// window, none otherwise. Results pass through five register stages (input,
// square, accumulate, threshold test, and the segment update together with
// the result register) after a window's last sample is taken. Throughput is
// one sample per cycle while in_tready is high, set by the accumulate stage
// that updates the window sum once per sample; in_tready is low during reset
// and otherwise falls only while a result sits in the skid register because
// the output side is stalled. A window length of zero discards every sample;
// lengths above WINDOW_MAX act as WINDOW_MAX. Configuration must be written
// only while no sample is in flight; the block itself does not enforce this.
module windowed_energy_peak_vad_core #(
  parameter int WINDOW_MAX      = wepvad_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH    = wepvad_pkg::SAMPLE_WIDTH_DEF,
  parameter int RUN_COUNT_WIDTH = wepvad_pkg::RUN_COUNT_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // sample (signed)
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // window_active, in_segment, segment_start, segment_end, keep_window
  output logic [wepvad_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                    cfg_we,
  input  logic [wepvad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wepvad_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int CMP_W = wepvad_pkg::max_int(wepvad_pkg::LEN_W, $clog2(WINDOW_MAX + 1));

  logic [wepvad_pkg::LEN_W-1:0]      window_length_r;
  logic [wepvad_pkg::SUM_W-1:0]      energy_sum_thr_r;
  logic [wepvad_pkg::PEAK_THR_W-1:0] peak_thr_r;
  logic [wepvad_pkg::RUN_CFG_W-1:0]  min_sound_r;
  logic [wepvad_pkg::RUN_CFG_W-1:0]  min_silence_r;
  logic [wepvad_pkg::RUN_CFG_W-1:0]  hangover_r;

  logic [CMP_W-1:0]     len_ext;
  logic [CMP_W-1:0]     len_eff;
  logic                 adv;
  logic                 in_take;
  wepvad_pkg::win_evt_t evt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r  <= wepvad_pkg::LEN_RST;
      energy_sum_thr_r <= wepvad_pkg::SUM_THR_RST;
      peak_thr_r       <= wepvad_pkg::PEAK_THR_RST;
      min_sound_r      <= wepvad_pkg::MIN_SOUND_RST;
      min_silence_r    <= wepvad_pkg::MIN_SILENCE_RST;
      hangover_r       <= wepvad_pkg::HANGOVER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wepvad_pkg::CFG_WINDOW_LENGTH: begin
          window_length_r <= cfg_wdata[wepvad_pkg::LEN_W-1:0];
        end
        wepvad_pkg::CFG_ENERGY_SUM_THR: begin
          energy_sum_thr_r <= cfg_wdata[wepvad_pkg::SUM_W-1:0];
        end
        wepvad_pkg::CFG_PEAK_THR: begin
          peak_thr_r <= cfg_wdata[wepvad_pkg::PEAK_THR_W-1:0];
        end
        wepvad_pkg::CFG_MIN_SOUND: begin
          min_sound_r <= cfg_wdata[wepvad_pkg::RUN_CFG_W-1:0];
        end
        wepvad_pkg::CFG_MIN_SILENCE: begin
          min_silence_r <= cfg_wdata[wepvad_pkg::RUN_CFG_W-1:0];
        end
        wepvad_pkg::CFG_HANGOVER: begin
          hangover_r <= cfg_wdata[wepvad_pkg::RUN_CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective window length, clamped to the largest supported window.
  always_comb begin
    len_ext = CMP_W'(window_length_r);
    len_eff = (len_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : len_ext;
  end

  // Samples taken while the window length is zero are dropped.
  assign in_tready = adv && rst_n;
  assign in_take   = in_tvalid && in_tready && (window_length_r != '0);

  wepvad_window #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_take   (in_take),
    .in_sample (in_tdata[SAMPLE_WIDTH-1:0]),
    .len_eff   (len_eff),
    .sum_thr   (energy_sum_thr_r),
    .peak_thr  (peak_thr_r),
    .evt       (evt)
  );

  wepvad_segment #(
    .WINDOW_MAX      (WINDOW_MAX),
    .RUN_COUNT_WIDTH (RUN_COUNT_WIDTH)
  ) u_segment (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt         (evt),
    .step        (len_eff),
    .min_sound   (min_sound_r),
    .min_silence (min_silence_r),
    .hangover    (hangover_r),
    .adv         (adv),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ----- tb/tb_windowed_energy_peak_vad_core.sv -----
// Self-checking testbench for windowed_energy_peak_vad_core: streams audio sample beats,
// predicts the per-window flags and checks every result beat against the prediction.
// Depends on wepvad_pkg and the RTL of the core only.
module tb_windowed_energy_peak_vad_core;
  import wepvad_pkg::*;

  localparam int IN_W          = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 500;

  // Flags of one finished window, window_active in bit 0.
  typedef struct packed {
    logic keep;
    logic seg_end;
    logic seg_start;
    logic in_seg;
    logic active;
  } window_flags_t;

  // Predicts the flags of every finished window and checks the result beats.
  class window_flag_tracker;
    // Register copies.
    logic [LEN_W-1:0]      win_len;
    logic [SUM_W-1:0]      sum_thr;
    logic [PEAK_THR_W-1:0] peak_thr;
    logic [RUN_CFG_W-1:0]  min_sound;
    logic [RUN_CFG_W-1:0]  min_silence;
    logic [RUN_CFG_W-1:0]  hangover;
    // Window and segment state.
    logic [SUM_W-1:0]      energy_acc;
    logic [15:0]           peak_mag;
    logic [LEN_W-1:0]      fill;
    logic                  seg_open;
    logic [RUN_CFG_W-1:0]  sound_run;
    logic [RUN_CFG_W-1:0]  silence_run;

    window_flags_t pending_flags[$];
    string field_tag[OUT_DATA_W];
    int errors, samples_used, windows, active_n, starts, ends;

    function new();
      field_tag = '{"window_active", "in_segment", "segment_start", "segment_end",
                    "keep_window", "padding", "padding", "padding"};
      win_len     = LEN_RST;
      sum_thr     = SUM_THR_RST;
      peak_thr    = PEAK_THR_RST;
      min_sound   = MIN_SOUND_RST;
      min_silence = MIN_SILENCE_RST;
      hangover    = HANGOVER_RST;
      energy_acc  = '0;
      peak_mag    = '0;
      fill        = '0;
      seg_open    = 1'b0;
      sound_run   = '0;
      silence_run = '0;
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WINDOW_LENGTH:  win_len     = val[LEN_W-1:0];
        CFG_ENERGY_SUM_THR: sum_thr     = val[SUM_W-1:0];
        CFG_PEAK_THR:       peak_thr    = val[PEAK_THR_W-1:0];
        CFG_MIN_SOUND:      min_sound   = val[RUN_CFG_W-1:0];
        CFG_MIN_SILENCE:    min_silence = val[RUN_CFG_W-1:0];
        CFG_HANGOVER:       hangover    = val[RUN_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    // Run counters stick at all ones.
    function logic [RUN_CFG_W-1:0] run_plus(logic [RUN_CFG_W-1:0] run, logic [LEN_W-1:0] step);
      logic [RUN_CFG_W:0] s;
      s = (RUN_CFG_W + 1)'(run) + (RUN_CFG_W + 1)'(step);
      return s[RUN_CFG_W] ? {RUN_CFG_W{1'b1}} : s[RUN_CFG_W-1:0];
    endfunction

    function int pending();
      return pending_flags.size();
    endfunction

    // Accumulates one accepted sample beat; a full window yields one set of flags.
    function void take_sample(logic [15:0] raw);
      logic [LEN_W-1:0] eff;
      logic [15:0]      mag;
      logic [31:0]      sq;
      logic [SUM_W:0]   acc;
      window_flags_t    f;
      if (win_len == 0) return;
      samples_used++;
      eff = (win_len > WINDOW_MAX_DEF) ? LEN_W'(WINDOW_MAX_DEF) : win_len;
      mag = raw[15] ? 16'(~raw + 16'd1) : raw;
      sq  = 32'(mag) * 32'(mag);
      acc = (SUM_W + 1)'(energy_acc) + (SUM_W + 1)'(sq);
      energy_acc = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
      if (mag > peak_mag) peak_mag = mag;
      fill = fill + 1'b1;
      // A lowered length ends the window as soon as the fill reaches or passes it.
      if (fill < eff) return;

      f = '0;
      f.active = (energy_acc > sum_thr) || (peak_mag > {1'b0, peak_thr});
      if (f.active) begin
        sound_run   = run_plus(sound_run, eff);
        silence_run = '0;
        if (!seg_open && sound_run >= min_sound) begin
          seg_open    = 1'b1;
          f.seg_start = 1'b1;
        end
      end else begin
        silence_run = run_plus(silence_run, eff);
        sound_run   = '0;
        if (seg_open && silence_run >= min_silence) begin
          seg_open  = 1'b0;
          f.seg_end = 1'b1;
        end
      end
      f.in_seg = seg_open;
      f.keep   = seg_open || (silence_run != 0 && silence_run <= hangover);
      pending_flags = {pending_flags, f};

      windows++;
      active_n += f.active;
      starts   += f.seg_start;
      ends     += f.seg_end;
      energy_acc = '0;
      peak_mag   = '0;
      fill       = '0;
    endfunction

    // Compares one result beat, field by field, with the oldest prediction.
    function void check_result(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      if (pending_flags.size() == 0) begin
        fail($sformatf("result beat 0x%02h arrived with no window pending", got));
        return;
      end
      want = OUT_DATA_W'(pending_flags.pop_front());
      for (int i = 0; i < OUT_DATA_W; i++) begin
        if (got[i] !== want[i])
          fail($sformatf("result beat 0x%02h, field %s: expected %b, actual %b",
                         got, field_tag[i], want[i], got[i]));
      end
    endfunction

    function void close_out();
      if (pending_flags.size() != 0)
        fail($sformatf("%0d predicted windows never produced a result beat",
                       pending_flags.size()));
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_WINDOW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  window_flag_tracker flags = new();

  bit               src_gaps    = 1'b0;
  bit               sink_stalls = 1'b0;
  int               stall_left  = 0;
  int               phases      = 0;
  int               fed         = 0;
  logic [LEN_W-1:0] cur_len     = LEN_RST;

  always #5 clk = ~clk;

  windowed_energy_peak_vad_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Beats on both channels are taken from the values held at the clock edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) flags.take_sample(in_tdata[15:0]);
    if (rst_n && out_tvalid && out_tready) flags.check_result(out_tdata);
  end

  // Gap lengths: the short range is drawn four times in five, the long range otherwise.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 19);
    return (r < 16) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Result side back-pressure.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= draw_gap() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Random sample within +/- amp; a full-scale amplitude covers every code.
  function automatic logic [15:0] draw_sample(int amp);
    if (amp >= 32768) return 16'($urandom);
    return 16'($urandom_range(0, 2 * amp) - amp);
  endfunction

  // Presents one sample beat, after an optional gap, and returns once it is taken.
  task automatic push_sample(input logic [15:0] s);
    int gap;
    gap = (src_gaps && $urandom_range(0, 3) == 0) ? draw_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cur_len != 0) fed++;
  endtask

  // Stops sending and waits for every predicted window, then for the pipeline to empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (flags.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    flags.set_reg(idx, val);
  endtask

  // Writes all six registers while the block is idle.
  task automatic apply_config(input logic [LEN_W-1:0] len, input logic [SUM_W-1:0] sthr,
                              input logic [PEAK_THR_W-1:0] pthr,
                              input logic [RUN_CFG_W-1:0] snd, input logic [RUN_CFG_W-1:0] sil,
                              input logic [RUN_CFG_W-1:0] hang);
    settle();
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_ENERGY_SUM_THR, CFG_DATA_W'(sthr));
    write_reg(CFG_PEAK_THR, CFG_DATA_W'(pthr));
    write_reg(CFG_MIN_SOUND, CFG_DATA_W'(snd));
    write_reg(CFG_MIN_SILENCE, CFG_DATA_W'(sil));
    write_reg(CFG_HANGOVER, CFG_DATA_W'(hang));
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_len = len;
    phases++;
  endtask

  // Runs of loud and quiet windows, with the odd sample of random level mixed in.
  task automatic feed_bursts(input int count, input int loud_amp, input int quiet_amp);
    int eff, left_in_run, in_win;
    bit loud;
    eff = (cur_len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : ((cur_len == 0) ? 1 : int'(cur_len));
    loud = $urandom_range(0, 1);
    left_in_run = $urandom_range(1, 6);
    in_win = 0;
    for (int n = 0; n < count; n++) begin
      int amp;
      amp = loud ? loud_amp : quiet_amp;
      if ($urandom_range(0, 15) == 0) amp = $urandom_range(0, 32768);
      push_sample(draw_sample(amp));
      in_win++;
      if (in_win >= eff) begin
        in_win = 0;
        left_in_run--;
        if (left_in_run == 0) begin
          loud = !loud;
          left_in_run = $urandom_range(1, 8);
        end
      end
      if ($urandom_range(0, 199) == 0) settle();
    end
  endtask

  // One random setting followed by a burst of samples; it often ends mid-window.
  task automatic random_phase();
    int r, eff, loud_amp, quiet_amp, count;
    longint unsigned lo_e, hi_e, sthr;
    logic [LEN_W-1:0] len;
    logic [PEAK_THR_W-1:0] pthr;
    logic [RUN_CFG_W-1:0] runs[3];
    r = $urandom_range(0, 19);
    if (r == 0) len = '0;
    else if (r < 15) len = LEN_W'($urandom_range(1, 16));
    else if (r < 19) len = LEN_W'($urandom_range(17, 64));
    else len = LEN_W'($urandom_range(65, 300));
    eff = (len == 0) ? 1 : int'(len);
    loud_amp  = $urandom_range(3000, 32768);
    quiet_amp = $urandom_range(0, 800);

    case ($urandom_range(0, 5))
      0: pthr = PEAK_THR_W'($urandom_range(0, 32767));
      1: pthr = '1;
      default: pthr = PEAK_THR_W'($urandom_range(quiet_amp,
                                                 (loud_amp > 32767) ? 32767 : loud_amp));
    endcase

    // Sum threshold as a mean energy between the quiet and loud levels, times the length.
    lo_e = longint'(quiet_amp) * quiet_amp / 3;
    hi_e = longint'(loud_amp) * loud_amp / 3;
    case ($urandom_range(0, 5))
      0: sthr = 0;
      1: sthr = 64'hFFFF_FFFF_FFFF;
      2: sthr = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
      default: sthr = eff * (lo_e + ($urandom % (hi_e - lo_e + 1)));
    endcase

    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 7))
        0: runs[i] = '0;
        1: runs[i] = '1;
        default: begin
          runs[i] = RUN_CFG_W'($urandom_range(0, 6) * eff);
          if ($urandom_range(0, 3) == 0)
            runs[i] = runs[i] + RUN_CFG_W'($urandom_range(0, eff));
        end
      endcase
    end

    src_gaps    = ($urandom_range(0, 3) != 0);
    sink_stalls = ($urandom_range(0, 3) != 0);
    apply_config(len, sthr[SUM_W-1:0], pthr, runs[0], runs[1], runs[2]);
    count = (len == 0) ? $urandom_range(3, 10) : $urandom_range(40, 160);
    feed_bursts(count, loud_amp, quiet_amp);
  endtask

  // Upper bound on the run, far above the slowest legal run.
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // One window under the reset settings.
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    phases      = 1;
    feed_bursts(int'(LEN_RST), 4000, 4000);

    // Single-sample windows: zero energy threshold, peak threshold at full scale,
    // segments open and close on any window, most negative sample.
    apply_config(1, '0, '1, '0, '0, '0);
    push_sample(16'h0000);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0000);

    // Max sum threshold and runs: nothing ever opens, hangover covers every silence.
    apply_config(1, '1, '0, '1, '1, '1);
    push_sample(16'h0000);
    push_sample(16'h0001);
    push_sample(16'h8000);
    push_sample(16'h0000);
    push_sample(16'h0000);

    // Energy sum just above, then exactly at, the threshold.
    apply_config(2, 48'd2147352577, '1, 24'd2, 24'd2, 24'd2);
    push_sample(16'h7FFF);
    push_sample(16'h7FFF);
    apply_config(2, 48'd2147352578, '1, 24'd2, 24'd2, 24'd2);
    push_sample(16'h7FFF);
    push_sample(16'h7FFF);

    // Zero window length: beats are swallowed without effect.
    apply_config(0, '0, '0, '0, '0, '0);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h1234);

    // Length above the maximum acts as the maximum, so no window ends here;
    // the length is then lowered below the fill, ending the window at once.
    apply_config('1, SUM_W'({$urandom, $urandom}), PEAK_THR_W'($urandom_range(0, 32767)),
                 '0, '0, 24'd4096);
    feed_bursts(150, 32768, 32768);
    apply_config(5, 48'd100000, 15'd300, 24'd10, 24'd5, 24'd15);
    feed_bursts(20, 20000, 200);

    // Random settings with bursty sound and silence.
    fed = 0;
    while (fed < RANDOM_ITEMS) random_phase();

    settle();
    flags.close_out();
    $display("Run summary: %0d samples over %0d settings, %0d windows checked.",
             flags.samples_used, phases, flags.windows);
    $display("Run summary: %0d active windows, %0d segment openings, %0d segment closings.",
             flags.active_n, flags.starts, flags.ends);
    if (flags.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
